// ===== rtl/core/dpg_pkg.sv =====
package dpg_pkg;

    typedef enum logic [1:0] {
        REQ_READ_DIR   = 2'd0,
        REQ_READ_DATA  = 2'd1,
        REQ_WRITE_DIR  = 2'd2,
        REQ_WRITE_DATA = 2'd3
    } req_type_t;

    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [7:0] MASK_MOTOR  = 8'h04;
    localparam int unsigned LED_BIT    = 3;
    localparam int unsigned RATE_SHIFT = 5;
    localparam logic [7:0] SENSE_WP    = 8'h10;
    localparam logic [7:0] SENSE_READY = 8'h80;
    localparam logic [7:0] SENSE_KEEP  = 8'h6F;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  write_value;
        logic        write_protect;
        logic        byte_ready;
        logic [31:0] elapsed;
    } dpg_item_t;

    typedef struct packed {
        logic [2:0]  bit_rate;
        logic [31:0] led_ticks;
        logic        led_on;
        logic        step_event;
        logic [1:0]  step_phase;
        logic        motor_on;
        logic [7:0]  read_data;
    } dpg_result_t;

endpackage

// ===== rtl/core/dpg_in_stage.sv =====
module dpg_in_stage
    import dpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_type_t   in_req_type,
    input  logic [7:0]  in_write_value,
    input  logic        in_write_protect,
    input  logic        in_byte_ready,
    input  logic [31:0] in_now,
    output logic        item_valid,
    input  logic        item_ready,
    output dpg_item_t   item
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] last_now_reg;
    logic [31:0] last_now_next;
    dpg_item_t   item_reg;
    dpg_item_t   item_next;
    logic        take;

    // The time since the previous request is formed here, because requests
    // leave this stage in the order in which they arrive.
    assign in_ready   = !valid_reg || item_ready;
    assign take       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next    = valid_reg;
        last_now_next = last_now_reg;
        item_next     = item_reg;
        if (valid_reg && item_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next              = 1'b1;
            last_now_next           = in_now;
            item_next.req_type      = in_req_type;
            item_next.write_value   = in_write_value;
            item_next.write_protect = in_write_protect;
            item_next.byte_ready    = in_byte_ready;
            item_next.elapsed       = in_now - last_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            last_now_reg <= '0;
        end else begin
            valid_reg    <= valid_next;
            last_now_reg <= last_now_next;
        end
        item_reg <= item_next;
    end

endmodule

// ===== rtl/core/dpg_port_core.sv =====
module dpg_port_core
    import dpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    output logic        item_ready,
    input  dpg_item_t   item,
    output logic        res_valid,
    input  logic        res_ready,
    output dpg_result_t res
);

    logic [7:0]  direction_reg;
    logic [7:0]  direction_next;
    logic [7:0]  data_reg;
    logic [7:0]  data_next;
    logic [7:0]  prev_pins_reg;
    logic [31:0] led_count_reg;
    logic [31:0] led_count_next;
    logic        res_valid_reg;
    dpg_result_t res_reg;
    dpg_result_t res_next;
    logic        fire;
    logic [7:0]  dir_eff;
    logic [7:0]  data_eff;
    logic [7:0]  pins;
    logic [7:0]  sense;
    logic        led;
    logic [32:0] led_sum;

    assign item_ready = !res_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb begin
        dir_eff  = (item.req_type == REQ_WRITE_DIR)  ? item.write_value : direction_reg;
        data_eff = (item.req_type == REQ_WRITE_DATA) ? item.write_value : data_reg;
        pins     = (data_eff & dir_eff) | ~dir_eff;
        led      = !pins[LED_BIT];
        led_sum  = {1'b0, led_count_reg} + {1'b0, item.elapsed};
        sense    = (item.write_protect ? SENSE_WP : 8'h00)
                 | (item.byte_ready ? SENSE_READY : 8'h00);

        direction_next = dir_eff;
        data_next      = pins & (sense | SENSE_KEEP);
        led_count_next = led_count_reg;
        if (led) begin
            led_count_next = led_sum[32] ? 32'hFFFF_FFFF : led_sum[31:0];
        end

        res_next.motor_on   = |(pins & MASK_MOTOR);
        res_next.step_phase = pins[1:0];
        res_next.step_event = |(pins[1:0] ^ prev_pins_reg[1:0]);
        res_next.led_on     = led;
        res_next.led_ticks  = led_count_next;
        res_next.bit_rate   = pins[RATE_SHIFT +: 3];
        case (item.req_type)
            REQ_READ_DIR:  res_next.read_data = direction_reg;
            REQ_READ_DATA: res_next.read_data = data_next;
            default:       res_next.read_data = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= '0;
            data_reg      <= '0;
            prev_pins_reg <= '0;
            led_count_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                direction_reg <= direction_next;
                data_reg      <= data_next;
                prev_pins_reg <= pins;
                led_count_reg <= led_count_next;
            end
            if (item_ready) begin
                res_valid_reg <= item_valid;
            end
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/drive_processor_port_glue_top.sv =====
// Channel   Ports               Contents
// s_        tvalid/tready/tdata bus request; tuser holds the request type
// m_        tvalid/tready/tdata one result for every request
//
// Each request passes from acceptance to result through the input register,
// then through the port update into the result register.
// One request is accepted in every cycle while the result side keeps up.
// Reset clears the direction, data and previous pin registers and the LED
// counter and time base. A stall on m_tready holds both stages in place.
module drive_processor_port_glue_top
    import dpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] req_type
    input  logic [1:0]            s_tuser,
    // [7:0] write_value, [8] write_protect, [9] byte_ready, [41:10] now, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] read_data, [8] motor_on, [10:9] step_phase, [11] step_event,
    // [12] led_on, [44:13] led_ticks, [47:45] bit_rate
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic        item_valid;
    logic        item_ready;
    dpg_item_t   item;
    dpg_result_t res;

    dpg_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_req_type      (req_type_t'(s_tuser)),
        .in_write_value   (s_tdata[7:0]),
        .in_write_protect (s_tdata[8]),
        .in_byte_ready    (s_tdata[9]),
        .in_now           (s_tdata[41:10]),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item)
    );

    dpg_port_core u_port_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = res;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dpg_pkg::*;

    localparam int LONG_HOLD   = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        req_type_t   kind;
        logic [7:0]  value;
        logic        wprot;
        logic        ready;
        logic [31:0] stamp;
    } bus_req_t;

    typedef struct {
        logic [7:0]  rdata;
        logic        motor;
        logic [1:0]  phase;
        logic        stepped;
        logic        led;
        logic [31:0] ticks;
        logic [2:0]  rate;
    } port_out_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [1:0]            s_tuser  = '0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predicted port state.
    logic [7:0]  ddr        = '0;
    logic [7:0]  odr        = '0;
    logic [7:0]  last_pins  = '0;
    logic [31:0] led_count  = '0;
    logic [31:0] last_stamp = '0;

    bus_req_t  bus_requests[$];
    port_out_t expected_port_results[$];
    bus_req_t  on_bus;

    int          send_gap      = 0;
    int          send_idle_max = 0;
    int          recv_idle_max = 0;
    int          recv_wait     = 0;
    int          holds_asked   = 0;
    int          holds_done    = 0;
    int          errors        = 0;
    int          results_seen  = 0;
    int          quiet_cycles  = 0;
    logic [31:0] stamp_now     = '0;

    int send_plan[PHASES] = '{0, 8, 0, 8, 0, 3};
    int recv_plan[PHASES] = '{0, 8, 8, 0, 3, 4};

    drive_processor_port_glue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic port_out_t port_access(bus_req_t r);
        port_out_t   o;
        logic [7:0]  pins;
        logic [32:0] sum;
        if (r.kind == REQ_WRITE_DIR) begin
            ddr = r.value;
        end else if (r.kind == REQ_WRITE_DATA) begin
            odr = r.value;
        end
        pins      = (odr & ddr) | ~ddr;
        o.motor   = pins[2];
        o.phase   = pins[1:0];
        o.stepped = (pins[1:0] != last_pins[1:0]);
        o.led     = ~pins[3];
        // The LED counter saturates instead of wrapping; elapsed time wraps.
        if (o.led) begin
            sum       = {1'b0, led_count} + {1'b0, r.stamp - last_stamp};
            led_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        last_stamp = r.stamp;
        o.ticks    = led_count;
        o.rate     = pins[7:5];
        odr        = pins & {r.ready, 2'b11, r.wprot, 4'b1111};
        last_pins  = pins;
        case (r.kind)
            REQ_READ_DIR:  o.rdata = ddr;
            REQ_READ_DATA: o.rdata = odr;
            default:       o.rdata = 8'h00;
        endcase
        return o;
    endfunction

    task automatic report_failure(input string msg);
        errors++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_failure($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                     results_seen, name, got, want));
        end
    endtask

    task automatic check_result();
        port_out_t want;
        results_seen++;
        if (expected_port_results.size() == 0) begin
            report_failure($sformatf("result %0d arrived with no request outstanding",
                                     results_seen));
            return;
        end
        want = expected_port_results.pop_front();
        check_field("read_data",  32'(m_tdata[7:0]),   32'(want.rdata));
        check_field("motor_on",   32'(m_tdata[8]),     32'(want.motor));
        check_field("step_phase", 32'(m_tdata[10:9]),  32'(want.phase));
        check_field("step_event", 32'(m_tdata[11]),    32'(want.stepped));
        check_field("led_on",     32'(m_tdata[12]),    32'(want.led));
        check_field("led_ticks",  m_tdata[44:13],      want.ticks);
        check_field("bit_rate",   32'(m_tdata[47:45]), 32'(want.rate));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_port_results.push_back(port_access(on_bus));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (bus_requests.size() > 0) begin
                    on_bus = bus_requests.pop_front();
                    s_tuser  <= on_bus.kind;
                    s_tdata  <= {6'd0, on_bus.stamp, on_bus.ready, on_bus.wprot,
                                 on_bus.value};
                    s_tvalid <= 1'b1;
                    send_gap = (send_idle_max > 0) ? $urandom_range(0, send_idle_max) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (holds_done != holds_asked) begin
                holds_done++;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready && recv_idle_max > 0) begin
                recv_wait = $urandom_range(0, recv_idle_max);
                m_tready <= (recv_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_req(input req_type_t kind, input logic [7:0] value,
                            input logic wprot, input logic ready,
                            input logic [31:0] stamp);
        bus_req_t r;
        r.kind  = kind;
        r.value = value;
        r.wprot = wprot;
        r.ready = ready;
        r.stamp = stamp;
        bus_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (bus_requests.size() != 0 || s_tvalid || expected_port_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic push_random(input int count);
        req_type_t  kind;
        logic [7:0] value;
        repeat (count) begin
            kind  = req_type_t'($urandom_range(0, 3));
            value = 8'($urandom_range(0, 255));
            if (kind == REQ_WRITE_DIR && $urandom_range(0, 3) == 0) begin
                value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            stamp_now += $urandom_range(0, 300);
            push_req(kind, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     stamp_now);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Every access kind, pin extremes, phase steps and a forward time wrap.
        push_req(REQ_READ_DIR,   8'h00, 1'b0, 1'b0, 32'd0);
        push_req(REQ_READ_DATA,  8'h00, 1'b1, 1'b1, 32'd10);
        push_req(REQ_WRITE_DATA, 8'hFF, 1'b0, 1'b0, 32'd20);
        push_req(REQ_WRITE_DIR,  8'hFF, 1'b1, 1'b0, 32'd30);
        push_req(REQ_WRITE_DATA, 8'h00, 1'b0, 1'b1, 32'd100);
        push_req(REQ_WRITE_DATA, 8'h04, 1'b0, 1'b0, 32'd150);
        push_req(REQ_WRITE_DATA, 8'h01, 1'b0, 1'b0, 32'd151);
        push_req(REQ_WRITE_DATA, 8'h02, 1'b0, 1'b0, 32'd151);
        push_req(REQ_WRITE_DATA, 8'h03, 1'b0, 1'b0, 32'd400);
        push_req(REQ_WRITE_DATA, 8'hE8, 1'b1, 1'b1, 32'd500);
        push_req(REQ_WRITE_DIR,  8'h0F, 1'b1, 1'b1, 32'd600);
        push_req(REQ_READ_DATA,  8'hFF, 1'b1, 1'b1, 32'd700);
        push_req(REQ_READ_DATA,  8'hFF, 1'b0, 1'b0, 32'd701);
        push_req(REQ_READ_DIR,   8'h55, 1'b0, 1'b1, 32'd702);
        push_req(REQ_WRITE_DIR,  8'h00, 1'b0, 1'b0, 32'hFFFF_FFF0);
        push_req(REQ_WRITE_DIR,  8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFA);
        push_req(REQ_WRITE_DATA, 8'h00, 1'b0, 1'b0, 32'h0000_0005);
        stamp_now = 32'h0000_0005;
        wait_drained();

        // The time base jumps only while the LED is off, so that the
        // counter stays clear of saturation through the random part.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            send_idle_max = send_plan[p];
            recv_idle_max = recv_plan[p];
            push_req(REQ_WRITE_DIR, 8'h00, 1'b0, 1'b0, stamp_now);
            stamp_now = (p == 2) ? 32'hFFFF_F000 : $urandom;
            push_req(REQ_READ_DIR, 8'h00, 1'b0, 1'b0, stamp_now);
            if (p == 4) begin
                holds_asked++;
            end
            push_random(PHASE_ITEMS);
        end
        wait_drained();

        // Time going backwards with the LED on, then counter saturation.
        send_idle_max = 0;
        recv_idle_max = 0;
        push_req(REQ_WRITE_DIR,  8'hFF, 1'b1, 1'b0, stamp_now + 32'd10);
        push_req(REQ_WRITE_DATA, 8'h00, 1'b0, 1'b1, stamp_now + 32'd20);
        push_req(REQ_READ_DATA,  8'h00, 1'b1, 1'b1, stamp_now - 32'h1000_0000);
        push_req(REQ_READ_DIR,   8'h00, 1'b0, 1'b0, stamp_now + 32'h2000_0000);
        push_req(REQ_WRITE_DATA, 8'h00, 1'b1, 1'b1, stamp_now + 32'h2000_0100);
        push_req(REQ_WRITE_DIR,  8'h00, 1'b0, 1'b0, stamp_now + 32'h2000_0200);
        wait_drained();

        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
